>>> src/rkc_pkg.sv
// shared types, register codes and helpers for the 3x3 rgba convolution
package rkc_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 16;
	localparam int IMW_W     = 11;
	localparam int SUM_W     = 24;
	localparam int PROD_W    = 43;
	localparam int T_W       = 44;

	localparam logic [2:0] REG_KERNEL_TOP    = 3'd0;
	localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd1;
	localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd2;
	localparam logic [2:0] REG_SCALE_FACTOR  = 3'd3;
	localparam logic [2:0] REG_BIAS_OFFSET   = 3'd4;
	localparam logic [2:0] REG_KEEP_ALPHA    = 3'd5;
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd6;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd7;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       frame_end;
	} result_t;

	typedef struct packed {
		logic [2:0][35:0]   kernel;
		logic [17:0]        scale;
		logic signed [13:0] bias;
		logic               keep_alpha;
		logic [IMW_W-1:0]   width;
		logic [ROW_W-1:0]   height;
	} cfg_t;

	// window indexed [row][column], one rgba word per sample
	typedef struct packed {
		logic [2:0][2:0][31:0] px;
		logic                  frame_end;
	} job_t;

	function automatic logic [IMW_W-1:0] eff_width(input logic [IMW_W-1:0] w);
		logic [IMW_W-1:0] r;
		r = w;
		if (w == '0) begin
			r = IMW_W'(1);
		end else if (w > IMW_W'(MAX_WIDTH)) begin
			r = IMW_W'(MAX_WIDTH);
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] h);
		return (h == '0) ? ROW_W'(1) : h;
	endfunction

	function automatic logic signed [11:0] coef(input logic [35:0] row, input logic [1:0] kx);
		logic signed [11:0] c;
		unique case (kx)
			2'd0: c = row[11:0];
			2'd1: c = row[23:12];
			2'd2: c = row[35:24];
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

>>> src/rkc_front.sv
// front end: accepts items, keeps the line stores and column window, builds 3x3 windows
module rkc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  rkc_pkg::cfg_t  cfg,
	input  rkc_pkg::item_t item,
	input  logic           push,
	output logic           full,
	output logic           jq_push,
	output rkc_pkg::job_t  jq_job,
	input  logic           jq_full
);

	typedef enum logic [5:0] {
		F_IDLE  = 6'b000001,
		F_READ  = 6'b000010,
		F_EMIT1 = 6'b000100,
		F_EMIT2 = 6'b001000,
		F_DRD   = 6'b010000,
		F_DPUSH = 6'b100000
	} fstate_t;

	localparam int CW = rkc_pkg::COL_W;
	localparam int RW = rkc_pkg::ROW_W;

	fstate_t state_q;

	logic [31:0] older_mem [rkc_pkg::MAX_WIDTH];
	logic [31:0] newer_mem [rkc_pkg::MAX_WIDTH];
	logic [31:0] old_rd_q, new_rd_q;
	logic [CW-1:0] rd_addr;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q;

	logic [rkc_pkg::IMW_W-1:0] w;
	logic [rkc_pkg::IMW_W-1:0] wm1;
	logic [RW-1:0] h;
	logic [CW-1:0] wm1_c, pix_col, drn_col, drn_l, drn_r;
	logic          pix_last, accept, pix_go, drn_go;

	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [31:0]   cur_q;
	logic          e1_q, e2_q;

	logic [2:0][2:0][31:0] cw_q;

	logic [2:0][CW-1:0] dcol_q;
	logic [2:0][31:0]   dold_q, dnew_q;
	logic [1:0]         dcnt_q;
	logic [1:0]         didx;
	logic               dlast_q;

	rkc_pkg::job_t job1, job2, jobd;

	assign w     = rkc_pkg::eff_width(cfg.width);
	assign h     = rkc_pkg::eff_height(cfg.height);
	assign wm1   = w - rkc_pkg::IMW_W'(1);
	assign wm1_c = wm1[CW-1:0];

	assign pix_col  = (in_col_q > wm1_c) ? wm1_c : in_col_q;
	assign pix_last = (pix_col == wm1_c);
	assign drn_col  = (out_col_q > wm1_c) ? wm1_c : out_col_q;
	assign drn_l    = (drn_col != '0) ? drn_col - CW'(1) : '0;
	assign drn_r    = (({1'b0, drn_col} + rkc_pkg::IMW_W'(1)) < w) ? drn_col + CW'(1) : wm1_c;

	assign full   = (state_q != F_IDLE);
	assign accept = push && !full;
	assign pix_go = accept && (item.operation == rkc_pkg::OP_PIXEL) && (in_row_q < h);
	assign drn_go = accept && (item.operation == rkc_pkg::OP_DRAIN) && (in_row_q >= h);
	assign didx   = dcnt_q - 2'd1;

	always_comb begin
		rd_addr = pix_col;
		if (state_q == F_DRD) begin
			unique case (dcnt_q)
				2'd1:    rd_addr = dcol_q[1];
				2'd2:    rd_addr = dcol_q[2];
				default: rd_addr = dcol_q[0];
			endcase
		end
	end

	// line stores: one read and one write port each
	always_ff @(posedge clk) begin
		old_rd_q <= older_mem[rd_addr];
		new_rd_q <= newer_mem[rd_addr];
		if (state_q == F_READ) begin
			older_mem[c_q] <= new_rd_q;
			newer_mem[c_q] <= cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_go) begin
			c_q   <= pix_col;
			r_q   <= in_row_q;
			cur_q <= {item.in_alpha, item.in_blue, item.in_green, item.in_red};
		end
		if (state_q == F_READ) begin
			cw_q[0]    <= cw_q[1];
			cw_q[1]    <= cw_q[2];
			cw_q[2][0] <= (r_q >= RW'(2)) ? old_rd_q : new_rd_q;
			cw_q[2][1] <= new_rd_q;
			cw_q[2][2] <= cur_q;
		end
		if (drn_go) begin
			dcol_q[0] <= drn_l;
			dcol_q[1] <= drn_col;
			dcol_q[2] <= drn_r;
			dlast_q   <= (drn_col == wm1_c);
		end
		if (state_q == F_DRD && dcnt_q != 2'd0) begin
			dold_q[didx] <= old_rd_q;
			dnew_q[didx] <= new_rd_q;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			job1.px[k][0] = (c_q >= CW'(2)) ? cw_q[0][k] : cw_q[1][k];
			job1.px[k][1] = cw_q[1][k];
			job1.px[k][2] = cw_q[2][k];
			job2.px[k][0] = (c_q >= CW'(1)) ? cw_q[1][k] : cw_q[2][k];
			job2.px[k][1] = cw_q[2][k];
			job2.px[k][2] = cw_q[2][k];
			jobd.px[0][k] = (h >= RW'(2)) ? dold_q[k] : dnew_q[k];
			jobd.px[1][k] = dnew_q[k];
			jobd.px[2][k] = dnew_q[k];
		end
		job1.frame_end = 1'b0;
		job2.frame_end = 1'b0;
		jobd.frame_end = dlast_q;
	end

	always_comb begin
		jq_push = 1'b0;
		jq_job  = job1;
		unique case (state_q)
			F_EMIT1: jq_push = !jq_full;
			F_EMIT2: begin
				jq_push = !jq_full;
				jq_job  = job2;
			end
			F_DPUSH: begin
				jq_push = !jq_full;
				jq_job  = jobd;
			end
			default: jq_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			e1_q      <= 1'b0;
			e2_q      <= 1'b0;
			dcnt_q    <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (pix_go) begin
						e1_q <= (in_row_q != '0) && (pix_col != '0);
						e2_q <= (in_row_q != '0) && pix_last;
						if (in_row_q != '0) begin
							out_col_q <= pix_last ? '0 : pix_col;
						end
						if (pix_last) begin
							in_col_q <= '0;
							in_row_q <= in_row_q + RW'(1);
						end else begin
							in_col_q <= pix_col + CW'(1);
						end
						state_q <= F_READ;
					end else if (drn_go) begin
						dcnt_q  <= '0;
						state_q <= F_DRD;
					end
				end
				F_READ: begin
					state_q <= e1_q ? F_EMIT1 : (e2_q ? F_EMIT2 : F_IDLE);
				end
				F_EMIT1: begin
					if (!jq_full) begin
						state_q <= e2_q ? F_EMIT2 : F_IDLE;
					end
				end
				F_EMIT2: begin
					if (!jq_full) begin
						state_q <= F_IDLE;
					end
				end
				F_DRD: begin
					dcnt_q <= dcnt_q + 2'd1;
					if (dcnt_q == 2'd3) begin
						state_q <= F_DPUSH;
					end
				end
				F_DPUSH: begin
					if (!jq_full) begin
						if (dlast_q) begin
							in_col_q  <= '0;
							in_row_q  <= '0;
							out_col_q <= '0;
						end else begin
							out_col_q <= dcol_q[1] + CW'(1);
						end
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

>>> src/rkc_job_queue.sv
// two-entry queue of windows between front end and arithmetic back end
module rkc_job_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rkc_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output rkc_pkg::job_t dout,
	output logic          empty
);

	rkc_pkg::job_t ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= !wp_q;
			end
			if (pop && !empty) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end

endmodule

>>> src/rkc_back.sv
// back end: multiply-accumulate over the window, scale, bias, round, saturate; alpha can pass through
module rkc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rkc_pkg::cfg_t    cfg,
	input  rkc_pkg::job_t    job,
	input  logic             job_empty,
	output logic             job_pop,
	output rkc_pkg::result_t result,
	output logic             empty,
	input  logic             pop
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_ACC  = 4'b0010,
		B_MUL  = 4'b0100,
		B_RND  = 4'b1000
	} bstate_t;

	localparam int SW = rkc_pkg::SUM_W;
	localparam int PW = rkc_pkg::PROD_W;
	localparam int TW = rkc_pkg::T_W;

	bstate_t state_q;
	logic [1:0] ky_q, kx_q;
	logic signed [SW-1:0] acc_q  [4];
	logic signed [PW-1:0] prod_q [4];
	logic signed [11:0]   c;
	logic signed [20:0]   term [4];
	logic signed [TW-1:0] t [4];
	logic [TW-1:0]        tr [4];
	logic [7:0]           val [4];
	logic [31:0]          tap;

	rkc_pkg::result_t ofm_q [2];
	logic       owp_q, orp_q;
	logic [1:0] ocnt_q;
	logic       of_full;
	rkc_pkg::result_t res_d;

	assign tap = job.px[ky_q][kx_q];
	assign c   = rkc_pkg::coef(cfg.kernel[ky_q], kx_q);

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			term[ch] = $signed({1'b0, tap[8*ch +: 8]}) * c;
			t[ch]    = {prod_q[ch][PW-1], prod_q[ch]}
				+ {{(TW-30){cfg.bias[13]}}, cfg.bias, 16'b0};
			tr[ch]   = t[ch] + TW'(1 << 19);
			// round half away from zero on a positive value, then clamp
			if (t[ch][TW-1] || t[ch] == '0) begin
				val[ch] = 8'd0;
			end else if (tr[ch][TW-1:20] > (TW-20)'(255)) begin
				val[ch] = 8'd255;
			end else begin
				val[ch] = tr[ch][27:20];
			end
		end
		res_d.out_red   = val[0];
		res_d.out_green = val[1];
		res_d.out_blue  = val[2];
		res_d.out_alpha = cfg.keep_alpha ? job.px[1][1][31:24] : val[3];
		res_d.frame_end = job.frame_end;
	end

	assign of_full = (ocnt_q == 2'd2);
	assign job_pop = (state_q == B_RND) && !of_full;
	assign empty   = (ocnt_q == 2'd0);
	assign result  = ofm_q[orp_q];

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 4; ch++) begin
			if (state_q == B_IDLE) begin
				acc_q[ch] <= '0;
			end else if (state_q == B_ACC) begin
				acc_q[ch] <= acc_q[ch] + {{(SW-21){term[ch][20]}}, term[ch]};
			end
			if (state_q == B_MUL) begin
				prod_q[ch] <= acc_q[ch] * $signed({1'b0, cfg.scale});
			end
		end
		if (job_pop) begin
			ofm_q[owp_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ky_q    <= '0;
			kx_q    <= '0;
			owp_q   <= 1'b0;
			orp_q   <= 1'b0;
			ocnt_q  <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					ky_q <= '0;
					kx_q <= '0;
					if (!job_empty) begin
						state_q <= B_ACC;
					end
				end
				B_ACC: begin
					if (kx_q == 2'd2) begin
						kx_q <= '0;
						ky_q <= ky_q + 2'd1;
						if (ky_q == 2'd2) begin
							state_q <= B_MUL;
						end
					end else begin
						kx_q <= kx_q + 2'd1;
					end
				end
				B_MUL: state_q <= B_RND;
				B_RND: begin
					if (!of_full) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (job_pop) begin
				owp_q <= !owp_q;
			end
			if (pop && !empty) begin
				orp_q <= !orp_q;
			end
			ocnt_q <= ocnt_q + {1'b0, job_pop} - {1'b0, pop && !empty};
		end
	end

endmodule

>>> src/rgba_kernel_convolution_3x3_core.sv
// top level of the streaming 3x3 rgba convolution with clamp-to-edge borders
// A pixel transaction occupies the front end for its accept, line store read
// and write and one emit step for each window it releases; a drain transaction
// reads the three columns of the window through the single read port of each
// line store one after another, then pushes the window. The front end takes no
// new item until its current transaction is done. The arithmetic unit works on
// one window at a time: it picks up the window, takes the nine taps at one per
// cycle, then does the scale multiply and the rounding step before the next one.
// Two windows wait between the two halves and two results wait at the output.
// The line stores need no clearing after reset; every entry is written before
// its contents are used.
module rgba_kernel_convolution_3x3_core (
	input  logic             clk,
	input  logic             arst_n,
	input  rkc_pkg::item_t   item,
	input  logic             push,
	output logic             full,
	output rkc_pkg::result_t result,
	output logic             empty,
	input  logic             pop,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [35:0]      cfg_data
);

	rkc_pkg::cfg_t cfg_q;
	rkc_pkg::job_t jq_din, jq_dout;
	logic jq_push, jq_full, jq_pop, jq_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel[0]  <= '0;
			cfg_q.kernel[1]  <= 36'd65536;
			cfg_q.kernel[2]  <= '0;
			cfg_q.scale      <= 18'd65536;
			cfg_q.bias       <= '0;
			cfg_q.keep_alpha <= 1'b0;
			cfg_q.width      <= 11'd1024;
			cfg_q.height     <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rkc_pkg::REG_KERNEL_TOP:    cfg_q.kernel[0]  <= cfg_data;
				rkc_pkg::REG_KERNEL_MIDDLE: cfg_q.kernel[1]  <= cfg_data;
				rkc_pkg::REG_KERNEL_BOTTOM: cfg_q.kernel[2]  <= cfg_data;
				rkc_pkg::REG_SCALE_FACTOR:  cfg_q.scale      <= cfg_data[17:0];
				rkc_pkg::REG_BIAS_OFFSET:   cfg_q.bias       <= $signed(cfg_data[13:0]);
				rkc_pkg::REG_KEEP_ALPHA:    cfg_q.keep_alpha <= cfg_data[0];
				rkc_pkg::REG_IMAGE_WIDTH:   cfg_q.width      <= cfg_data[10:0];
				rkc_pkg::REG_IMAGE_HEIGHT:  cfg_q.height     <= cfg_data[15:0];
			endcase
		end
	end

	rkc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (item),
		.push    (push),
		.full    (full),
		.jq_push (jq_push),
		.jq_job  (jq_din),
		.jq_full (jq_full)
	);

	rkc_job_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.din    (jq_din),
		.full   (jq_full),
		.pop    (jq_pop),
		.dout   (jq_dout),
		.empty  (jq_empty)
	);

	rkc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (jq_dout),
		.job_empty (jq_empty),
		.job_pop   (jq_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	// a window is never offered to a queue that cannot take it
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(jq_push && jq_full))
		else $error("window pushed into full queue");

	// the back end only finishes a window that is really there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(jq_pop && jq_empty))
		else $error("window taken from empty queue");

	// a finished window leaves the queue in the same cycle its result lands
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		jq_pop |=> !empty)
		else $error("result lost after window retired");

endmodule
